// ----- rtl/core/ptc_pkg.sv -----
// shared types, constants and helpers of the pressure/temperature compensation unit
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  localparam int unsigned DivLatency   = 32;
  localparam int unsigned FrontLatency = 12;
  localparam int unsigned BackLatency  = 3;

  localparam logic [31:0] FineOffset  = 32'd64000;
  localparam logic [31:0] AdcFull     = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] Half15      = 32'd32768;
  localparam logic [31:0] RoundTemp   = 32'd128;

  typedef enum logic [1:0] {
    RegCalT  = 2'd0,
    RegCalPa = 2'd1,
    RegCalPb = 2'd2,
    RegCalPc = 2'd3
  } reg_idx_e;

  // calibration coefficients, already widened to 32 bits
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } cal_t;

  // what rides alongside the divider
  typedef struct packed {
    logic [23:0] temp;
    logic        post;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] num;
    logic [31:0] den;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] quo;
    side_t       side;
  } div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pressure_temperature_compensation_unit.sv -----
// top level of the pressure/temperature compensation unit
//
// usage:
//   start with adc_temperature_i / adc_pressure_i is one reading pair; it is
//   taken on every edge where start is high and busy is low. busy stays low,
//   so a new pair can be given in every cycle.
//   calibration registers are written through cfg_valid_i / cfg_index_i /
//   cfg_data_i; cfg_ready_o is always high. write only while no item is
//   in flight. indexes: 0 temperature coeffs, 1..3 pressure coeffs.
//   each result appears for one cycle with out_valid_o high, after its
//   transfer has passed 12 stages of formula, 32 divider stages (one quotient bit
//   per stage) and 3 correction stages. throughput is one item per cycle.
//   results cannot be held off; the pipeline never stalls.
//   reset clears all valid bits and all calibration registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module pressure_temperature_compensation_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] adc_temperature_i,
  input  wire logic [19:0] adc_pressure_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output logic             out_valid_o,
  output logic [23:0]      temperature_centi_o,
  output logic [31:0]      pressure_pa_o,
  output logic             divisor_zero_o
);

  logic [47:0] cal_t_q;
  logic [63:0] cal_pa_q, cal_pb_q;
  logic [15:0] cal_pc_q;
  ptc_pkg::cal_t     cal;
  ptc_pkg::div_req_t req;
  ptc_pkg::div_rsp_t rsp;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q  <= '0;
      cal_pa_q <= '0;
      cal_pb_q <= '0;
      cal_pc_q <= '0;
    end else if (cfg_valid_i) begin
      case (ptc_pkg::reg_idx_e'(cfg_index_i))
        ptc_pkg::RegCalT:  cal_t_q  <= cfg_data_i[47:0];
        ptc_pkg::RegCalPa: cal_pa_q <= cfg_data_i;
        ptc_pkg::RegCalPb: cal_pb_q <= cfg_data_i;
        ptc_pkg::RegCalPc: cal_pc_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = {16'd0, cal_t_q[15:0]};
    cal.t2 = {{16{cal_t_q[31]}}, cal_t_q[31:16]};
    cal.t3 = {{16{cal_t_q[47]}}, cal_t_q[47:32]};
    cal.p1 = {16'd0, cal_pa_q[15:0]};
    cal.p2 = {{16{cal_pa_q[31]}}, cal_pa_q[31:16]};
    cal.p3 = {{16{cal_pa_q[47]}}, cal_pa_q[47:32]};
    cal.p4 = {{16{cal_pa_q[63]}}, cal_pa_q[63:48]};
    cal.p5 = {{16{cal_pb_q[15]}}, cal_pb_q[15:0]};
    cal.p6 = {{16{cal_pb_q[31]}}, cal_pb_q[31:16]};
    cal.p7 = {{16{cal_pb_q[47]}}, cal_pb_q[47:32]};
    cal.p8 = {{16{cal_pb_q[63]}}, cal_pb_q[63:48]};
    cal.p9 = {{16{cal_pc_q[15]}}, cal_pc_q};
  end

  ptc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start & ~busy),
    .adc_t_i    (adc_temperature_i),
    .adc_p_i    (adc_pressure_i),
    .cal_i      (cal),
    .req_o      (req)
  );

  ptc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  ptc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsp_i       (rsp),
    .cal_i       (cal),
    .out_valid_o (out_valid_o),
    .temp_o      (temperature_centi_o),
    .press_o     (pressure_pa_o),
    .zero_o      (divisor_zero_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ptc_front.sv -----
// temperature formula and pressure divisor/dividend stages
`timescale 1ns / 1ps
`default_nettype none
module ptc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [19:0]     adc_t_i,
  input  wire logic [19:0]     adc_p_i,
  input  wire ptc_pkg::cal_t   cal_i,
  output ptc_pkg::div_req_t    req_o
);

  logic [11:0] vld_q;

  logic [31:0] s1_x_q, s1_d_q;
  logic [31:0] s2_m_q, s2_dd_q;
  logic [31:0] s3_a_q, s3_e_q;
  logic [31:0] s4_a_q, s4_m_q;
  logic [31:0] s5_fine_q;
  logic [31:0] s6_pa_q;
  logic [31:0] s7_sq_q, s7_m5_q, s7_m2_q;
  logic [31:0] s8_b_q, s8_c_q, s8_m5_q, s8_m2_q;
  logic [31:0] s9_b_q, s9_a_q;
  logic [31:0] s10_a_q, s10_pre_q;
  logic [31:0] s11_a_q, s11_pn_q;
  logic [19:0] adcp_q [9];
  logic [23:0] temp_q [6];
  logic [31:0] req_num_q, req_den_q;
  logic        req_post_q, req_zero_q;
  logic [23:0] req_temp_q;

  logic [31:0] fine5, temp_full, q2, sq11, sq13;

  always_comb begin
    fine5     = (s5_fine_q << 2) + s5_fine_q;
    temp_full = ptc_pkg::asr(fine5 + ptc_pkg::RoundTemp, 8);
    q2        = ptc_pkg::asr(s6_pa_q, 2);
    sq11      = ptc_pkg::asr(s7_sq_q, 11);
    sq13      = ptc_pkg::asr(s7_sq_q, 13);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[10:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    s1_x_q    <= ({12'd0, adc_t_i} >> 3) - (cal_i.t1 << 1);
    s1_d_q    <= ({12'd0, adc_t_i} >> 4) - cal_i.t1;
    adcp_q[0] <= adc_p_i;
    for (int i = 1; i < 9; i++) begin
      adcp_q[i] <= adcp_q[i-1];
    end
    // stage 2
    s2_m_q  <= s1_x_q * cal_i.t2;
    s2_dd_q <= s1_d_q * s1_d_q;
    // stage 3
    s3_a_q <= ptc_pkg::asr(s2_m_q, 11);
    s3_e_q <= ptc_pkg::asr(s2_dd_q, 12);
    // stage 4
    s4_a_q <= s3_a_q;
    s4_m_q <= s3_e_q * cal_i.t3;
    // stage 5
    s5_fine_q <= s4_a_q + ptc_pkg::asr(s4_m_q, 14);
    // stage 6
    temp_q[0] <= temp_full[23:0];
    for (int i = 1; i < 6; i++) begin
      temp_q[i] <= temp_q[i-1];
    end
    s6_pa_q <= ptc_pkg::asr(s5_fine_q, 1) - ptc_pkg::FineOffset;
    // stage 7
    s7_sq_q <= q2 * q2;
    s7_m5_q <= s6_pa_q * cal_i.p5;
    s7_m2_q <= cal_i.p2 * s6_pa_q;
    // stage 8
    s8_b_q  <= sq11 * cal_i.p6;
    s8_c_q  <= cal_i.p3 * sq13;
    s8_m5_q <= s7_m5_q;
    s8_m2_q <= s7_m2_q;
    // stage 9
    s9_b_q <= ptc_pkg::asr(s8_b_q + (s8_m5_q << 1), 2) + (cal_i.p4 << 16);
    s9_a_q <= ptc_pkg::asr(ptc_pkg::asr(s8_c_q, 3) + ptc_pkg::asr(s8_m2_q, 1), 18);
    // stage 10
    s10_a_q   <= (ptc_pkg::Half15 + s9_a_q) * cal_i.p1;
    s10_pre_q <= (ptc_pkg::AdcFull - {12'd0, adcp_q[8]}) - ptc_pkg::asr(s9_b_q, 12);
    // stage 11
    s11_a_q  <= ptc_pkg::asr(s10_a_q, 15);
    s11_pn_q <= s10_pre_q * ptc_pkg::PressScale;
    // stage 12: large dividends are divided first and doubled after
    req_zero_q <= (s11_a_q == '0);
    req_den_q  <= (s11_a_q == '0) ? 32'd1 : s11_a_q;
    req_post_q <= s11_pn_q[31];
    req_num_q  <= s11_pn_q[31] ? s11_pn_q : (s11_pn_q << 1);
    req_temp_q <= temp_q[5];
  end

  assign req_o.vld       = vld_q[11];
  assign req_o.num       = req_num_q;
  assign req_o.den       = req_den_q;
  assign req_o.side.temp = req_temp_q;
  assign req_o.side.post = req_post_q;
  assign req_o.side.zero = req_zero_q;

endmodule
`default_nettype wire

// ----- rtl/core/ptc_div.sv -----
// pipelined unsigned 32-bit restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ptc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ptc_pkg::div_req_t  req_i,
  output ptc_pkg::div_rsp_t       rsp_o
);

  localparam int unsigned N = ptc_pkg::DivLatency;

  logic [N:0]  vld;
  logic [31:0] num [N+1];
  logic [31:0] den [N+1];
  logic [31:0] rem [N+1];
  logic [31:0] quo [N+1];
  ptc_pkg::side_t side [N+1];

  assign vld[0]  = req_i.vld;
  assign num[0]  = req_i.num;
  assign den[0]  = req_i.den;
  assign rem[0]  = '0;
  assign quo[0]  = '0;
  assign side[0] = req_i.side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [32:0] rem_sh, rem_sub;
    logic        ge;
    logic        vld_q;
    logic [31:0] num_q, den_q, rem_q, quo_q;
    ptc_pkg::side_t side_q;

    always_comb begin
      rem_sh  = {rem[i], num[i][31]};
      rem_sub = rem_sh - {1'b0, den[i]};
      ge      = (rem_sh >= {1'b0, den[i]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q  <= num[i] << 1;
      den_q  <= den[i];
      rem_q  <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q  <= {quo[i][30:0], ge};
      side_q <= side[i];
    end

    assign vld[i+1]  = vld_q;
    assign num[i+1]  = num_q;
    assign den[i+1]  = den_q;
    assign rem[i+1]  = rem_q;
    assign quo[i+1]  = quo_q;
    assign side[i+1] = side_q;
  end

  assign rsp_o.vld  = vld[N];
  assign rsp_o.quo  = quo[N];
  assign rsp_o.side = side[N];

endmodule
`default_nettype wire

// ----- rtl/core/ptc_back.sv -----
// pressure correction stages after the divide
`timescale 1ns / 1ps
`default_nettype none
module ptc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ptc_pkg::div_rsp_t  rsp_i,
  input  wire ptc_pkg::cal_t      cal_i,
  output logic                    out_valid_o,
  output logic [23:0]             temp_o,
  output logic [31:0]             press_o,
  output logic                    zero_o
);

  logic [2:0]  vld_q;
  logic [31:0] b1_p_q, b1_m_q, b1_m8_q;
  logic [31:0] b2_p_q, b2_m9_q, b2_b_q;
  logic [23:0] temp_q [3];
  logic        zero_q [3];
  logic [31:0] press_q;
  logic [31:0] p, p3, a, sum;

  always_comb begin
    p   = rsp_i.side.post ? (rsp_i.quo << 1) : rsp_i.quo;
    p3  = p >> 3;
    a   = ptc_pkg::asr(b2_m9_q, 12);
    sum = b2_p_q + ptc_pkg::asr(a + b2_b_q + cal_i.p7, 4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], rsp_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    b1_p_q    <= p;
    b1_m_q    <= p3 * p3;
    b1_m8_q   <= (p >> 2) * cal_i.p8;
    b2_p_q    <= b1_p_q;
    b2_m9_q   <= cal_i.p9 * (b1_m_q >> 13);
    b2_b_q    <= ptc_pkg::asr(b1_m8_q, 13);
    press_q   <= zero_q[1] ? '0 : sum;
    temp_q[0] <= rsp_i.side.temp;
    zero_q[0] <= rsp_i.side.zero;
    for (int i = 1; i < 3; i++) begin
      temp_q[i] <= temp_q[i-1];
      zero_q[i] <= zero_q[i-1];
    end
  end

  assign out_valid_o = vld_q[2];
  assign temp_o      = temp_q[2];
  assign press_o     = press_q;
  assign zero_o      = zero_q[2];

endmodule
`default_nettype wire

// ----- rtl/core/ptc_checker.sv -----
// port-level checks for the compensation unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        cfg_ready_o,
  input wire logic        out_valid_o,
  input wire logic [31:0] pressure_pa_o,
  input wire logic        divisor_zero_o
);

  localparam int unsigned Lat = ptc_pkg::FrontLatency + ptc_pkg::DivLatency
                                + ptc_pkg::BackLatency;

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat out_valid_o)
    else $error("result missing after transfer");

  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divisor_zero_o) |-> (pressure_pa_o == '0))
    else $error("nonzero pressure with zero divisor");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cfg_ready_o    (cfg_ready_o),
  .out_valid_o    (out_valid_o),
  .pressure_pa_o  (pressure_pa_o),
  .divisor_zero_o (divisor_zero_o)
);
`default_nettype wire
